// ===== hdl/mfep_pkg.sv =====
// Shared types, codes and tag tables for the MIDI file event parser.
`timescale 1ns / 1ps
`default_nettype none
package mfep_pkg;

  // Result kinds
  localparam logic [2:0] K_NOTE_ON  = 3'd0;
  localparam logic [2:0] K_NOTE_OFF = 3'd1;
  localparam logic [2:0] K_PROGRAM  = 3'd2;
  localparam logic [2:0] K_TEMPO    = 3'd3;
  localparam logic [2:0] K_TIMESIG  = 3'd4;
  localparam logic [2:0] K_DONE     = 3'd5;
  localparam logic [2:0] K_ERROR    = 3'd6;

  // Error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_HEADER   = 3'd1;
  localparam logic [2:0] E_FORMAT   = 3'd2;
  localparam logic [2:0] E_DIVISION = 3'd3;
  localparam logic [2:0] E_TRUNC    = 3'd4;
  localparam logic [2:0] E_TRACK    = 3'd5;
  localparam logic [2:0] E_EVENT    = 3'd6;

  // Parser phases
  localparam logic [3:0] P_HDR       = 4'd0;
  localparam logic [3:0] P_HDR_SKIP  = 4'd1;
  localparam logic [3:0] P_TRK_TAG   = 4'd2;
  localparam logic [3:0] P_TRK_LEN   = 4'd3;
  localparam logic [3:0] P_DELTA     = 4'd4;
  localparam logic [3:0] P_STATUS    = 4'd5;
  localparam logic [3:0] P_CH_D1     = 4'd6;
  localparam logic [3:0] P_CH_D2     = 4'd7;
  localparam logic [3:0] P_META_TYPE = 4'd8;
  localparam logic [3:0] P_VAR_LEN   = 4'd9;
  localparam logic [3:0] P_META_DATA = 4'd10;
  localparam logic [3:0] P_DATA_SKIP = 4'd11;
  localparam logic [3:0] P_TRK_SKIP  = 4'd12;
  localparam logic [3:0] P_TAIL      = 4'd13;
  localparam logic [3:0] P_STOP      = 4'd14;

  // Status and meta bytes
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_ESCAPE   = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_TSIG   = 8'h58;
  localparam logic [15:0] DIV_SMPTE  = 16'h8000;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tick;
    logic [31:0] seq;
    logic [15:0] track;
    logic [3:0]  channel;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [23:0] value;
    logic [2:0]  err;
    logic [31:0] end_tick;
    logic [31:0] start_tick;
  } res_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

  // "MThd"
  function automatic logic [7:0] head_tag(input logic [1:0] i);
    logic [7:0] t;
    case (i)
      2'd0: t = 8'h4D;
      2'd1: t = 8'h54;
      2'd2: t = 8'h68;
      default: t = 8'h64;
    endcase
    return t;
  endfunction

  // "MTrk"
  function automatic logic [7:0] chunk_tag(input logic [1:0] i);
    logic [7:0] t;
    case (i)
      2'd0: t = 8'h4D;
      2'd1: t = 8'h54;
      2'd2: t = 8'h72;
      default: t = 8'h6B;
    endcase
    return t;
  endfunction

  function automatic logic one_data(input logic [7:0] st);
    return (st[7:4] == 4'hC) || (st[7:4] == 4'hD);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/midi_file_event_parser_unit.sv =====
// Top level of the Standard MIDI File event parser.
`timescale 1ns / 1ps
`default_nettype none
// Parses a Standard MIDI File fed one byte per transfer (first_byte starts a new file,
// last_byte marks its end) and delivers note-on, note-off, program, tempo and
// time-signature events, then a done or error result. A byte is registered on transfer
// and decoded in the next cycle by a single pass of logic against the parser state;
// its results go to an 8-entry result queue. One byte is taken per cycle as long as the
// queue holds two results or fewer, so with the output side draining the rate is one
// byte per cycle; results pass the staging register, then the queue's registered head.
module midi_file_event_parser_unit import mfep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_tick,
  output logic [31:0]      out_sequence_res,
  output logic [15:0]      out_track_index,
  output logic [3:0]       out_channel,
  output logic [7:0]       out_data1,
  output logic [7:0]       out_data2,
  output logic [23:0]      out_value,
  output logic [2:0]       out_error_code,
  output logic [31:0]      out_end_tick,
  output logic [31:0]      out_music_start_tick
);

  logic       stg_valid_r;
  logic [7:0] stg_byte_r;
  logic       stg_first_r, stg_last_r;
  push_t      push;
  res_t       res0, res1, head;
  fifo_stat_t fstat;
  logic       pop;

  // Take a byte while the queue has room for everything in flight
  assign in_ready = (fstat.count <= FIFO_CW'(FIFO_DEPTH - 6));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r  <= in_data_byte;
      stg_first_r <= in_first_byte;
      stg_last_r  <= in_last_byte;
    end
  end

  mfep_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (stg_valid_r),
    .byte_in  (stg_byte_r),
    .first_in (stg_first_r),
    .last_in  (stg_last_r),
    .push     (push),
    .res0     (res0),
    .res1     (res1)
  );

  assign pop = out_valid && out_ready;

  mfep_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din0      (res0),
    .din1      (res1),
    .pop       (pop),
    .dout      (head),
    .not_empty (out_valid),
    .stat      (fstat)
  );

  assign out_kind             = head.kind;
  assign out_tick             = head.tick;
  assign out_sequence_res     = head.seq;
  assign out_track_index      = head.track;
  assign out_channel          = head.channel;
  assign out_data1            = head.data1;
  assign out_data2            = head.data2;
  assign out_value            = head.value;
  assign out_error_code       = head.err;
  assign out_end_tick         = head.end_tick;
  assign out_music_start_tick = head.start_tick;

  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Second result slot only with the first
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second result without first");

  // Done carries no error code; error carries one
  a_done_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_DONE) |-> (out_error_code == E_NONE))
    else $error("done result with error code");

  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_ERROR) |-> (out_error_code != E_NONE))
    else $error("error result without code");

endmodule
`default_nettype wire

// ===== hdl/mfep_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one.
`timescale 1ns / 1ps
`default_nettype none
module mfep_fifo import mfep_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire push_t push,
  input  wire res_t  din0,
  input  wire res_t  din1,
  input  wire logic  pop,
  output res_t       dout,
  output logic       not_empty,
  output fifo_stat_t stat
);

  res_t               mem [FIFO_DEPTH];
  res_t               dout_r;
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic [FIFO_AW-1:0] wp_nxt, rp_nxt;
  logic [FIFO_AW-1:0] wp1;

  assign wp1 = wp_r + 1'b1;

  // Advance pointers and count
  always_comb begin
    wp_nxt    = wp_r + FIFO_AW'(push.push0) + FIFO_AW'(push.push1);
    rp_nxt    = rp_r + FIFO_AW'(pop);
    count_nxt = count_r + FIFO_CW'(push.push0) + FIFO_CW'(push.push1) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wp_r] <= din0;
    end
    if (push.push1) begin
      mem[wp1] <= din1;
    end
  end

  // Read the next head entry, bypassing a write to the same slot
  always_ff @(posedge clk) begin
    if (push.push0 && wp_r == rp_nxt) begin
      dout_r <= din0;
    end else if (push.push1 && wp1 == rp_nxt) begin
      dout_r <= din1;
    end else begin
      dout_r <= mem[rp_nxt];
    end
  end

  assign dout       = dout_r;
  assign not_empty  = (count_r != '0);
  assign stat.count = count_r;

endmodule
`default_nettype wire

// ===== hdl/mfep_core.sv =====
// Byte-wise parser state and decode: one file byte per step, up to two results.
`timescale 1ns / 1ps
`default_nettype none
module mfep_core import mfep_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  input  wire logic       first_in,
  input  wire logic       last_in,
  output push_t           push,
  output res_t            res0,
  output res_t            res1
);

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  fld_r, fld_nxt;
  logic [3:0]  fbc_r, fbc_nxt;
  logic [31:0] hlen_r, hlen_nxt;
  logic [15:0] ntrk_r, ntrk_nxt;
  logic [15:0] ctrk_r, ctrk_nxt;
  logic [31:0] tbl_r, tbl_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [7:0]  es_r, es_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  meta_r, meta_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] evc_r, evc_nxt;
  logic [31:0] early_r, early_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] late_r, late_nxt;
  logic        ended_r, ended_nxt;
  logic        err_r, err_nxt;
  logic        tagbad_r, tagbad_nxt;
  logic        ovr_r, ovr_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] div_r, div_nxt;

  logic        do_emit, do_chan, do_data, do_fin_ev, do_fin_trk, do_fail;
  logic [2:0]  em_kind, fail_code;
  logic [3:0]  em_ch;
  logic [7:0]  em_d1, em_d2;
  logic [23:0] em_val;
  logic [7:0]  cd1, cd2;
  logic        v0, v1;
  res_t        r0, r1, rn;

  always_comb begin
    // Start from held state, or from reset state on a new file
    phase_nxt = phase_r; fld_nxt = fld_r; fbc_nxt = fbc_r; hlen_nxt = hlen_r;
    ntrk_nxt = ntrk_r; ctrk_nxt = ctrk_r; tbl_nxt = tbl_r; tick_nxt = tick_r;
    rs_nxt = rs_r; es_nxt = es_r; held_nxt = held_r; meta_nxt = meta_r;
    acc_nxt = acc_r; skip_nxt = skip_r; evc_nxt = evc_r; early_nxt = early_r;
    seen_nxt = seen_r; late_nxt = late_r; ended_nxt = ended_r; err_nxt = err_r;
    tagbad_nxt = tagbad_r; ovr_nxt = ovr_r; fmt_nxt = fmt_r; div_nxt = div_r;
    if (first_in) begin
      phase_nxt = P_HDR; fld_nxt = '0; fbc_nxt = '0; hlen_nxt = '0;
      ntrk_nxt = '0; ctrk_nxt = '0; tbl_nxt = '0; tick_nxt = '0;
      rs_nxt = '0; es_nxt = '0; held_nxt = '0; meta_nxt = '0;
      acc_nxt = '0; skip_nxt = '0; evc_nxt = '0; early_nxt = '0;
      seen_nxt = 1'b0; late_nxt = '0; ended_nxt = 1'b0; err_nxt = 1'b0;
      tagbad_nxt = 1'b0; ovr_nxt = 1'b0; fmt_nxt = '0; div_nxt = '0;
    end

    do_emit = 1'b0; do_chan = 1'b0; do_data = 1'b0; do_fin_ev = 1'b0;
    do_fin_trk = 1'b0; do_fail = 1'b0; fail_code = E_NONE;
    em_kind = K_NOTE_ON; em_ch = '0; em_d1 = '0; em_d2 = '0; em_val = '0;
    cd1 = '0; cd2 = '0;
    v0 = 1'b0; v1 = 1'b0; r0 = '0; r1 = '0; rn = '0;

    // Decode one byte by phase
    case (phase_nxt)
      P_HDR: begin
        if (fbc_nxt < 4'd4) begin
          if (byte_in != head_tag(fbc_nxt[1:0])) tagbad_nxt = 1'b1;
        end else if (fbc_nxt < 4'd8) begin
          hlen_nxt = {hlen_nxt[23:0], byte_in};
        end else if (fbc_nxt < 4'd10) begin
          fmt_nxt = {fmt_nxt[7:0], byte_in};
        end else if (fbc_nxt < 4'd12) begin
          ntrk_nxt = {ntrk_nxt[7:0], byte_in};
        end else begin
          div_nxt = {div_nxt[7:0], byte_in};
        end
        if (fbc_nxt == 4'd13) begin
          // Judge the header
          if (tagbad_nxt) begin
            do_fail = 1'b1; fail_code = E_HEADER;
          end else if (hlen_nxt < 32'd6) begin
            do_fail = 1'b1; fail_code = E_TRUNC;
          end else if (fmt_nxt > 16'd1 || ntrk_nxt == '0) begin
            do_fail = 1'b1; fail_code = E_FORMAT;
          end else if ((div_nxt & DIV_SMPTE) != '0 || div_nxt == '0) begin
            do_fail = 1'b1; fail_code = E_DIVISION;
          end else begin
            skip_nxt = hlen_nxt - 32'd6;
            fld_nxt = '0;
            phase_nxt = (skip_nxt != '0) ? P_HDR_SKIP : P_TRK_TAG;
          end
        end
        fbc_nxt = fbc_nxt + 4'd1;
      end
      P_HDR_SKIP: begin
        skip_nxt = skip_nxt - 32'd1;
        if (skip_nxt == '0) begin
          phase_nxt = P_TRK_TAG; fld_nxt = '0;
        end
      end
      P_TRK_TAG: begin
        if (byte_in != chunk_tag(fld_nxt[1:0])) begin
          do_fail = 1'b1; fail_code = E_TRACK;
        end else begin
          fld_nxt = fld_nxt + 3'd1;
          if (fld_nxt == 3'd4) begin
            phase_nxt = P_TRK_LEN; fld_nxt = '0; tbl_nxt = '0;
          end
        end
      end
      P_TRK_LEN: begin
        tbl_nxt = {tbl_nxt[23:0], byte_in};
        fld_nxt = fld_nxt + 3'd1;
        if (fld_nxt == 3'd4) begin
          tick_nxt = '0; rs_nxt = '0; ended_nxt = 1'b0; ovr_nxt = 1'b0;
          if (tbl_nxt == '0) begin
            do_fin_trk = 1'b1;
          end else begin
            phase_nxt = P_DELTA; fld_nxt = '0; acc_nxt = '0;
          end
        end
      end
      P_DELTA: begin
        if (tbl_nxt != '0) tbl_nxt = tbl_nxt - 32'd1; else ovr_nxt = 1'b1;
        acc_nxt = {acc_nxt[24:0], byte_in[6:0]};
        fld_nxt = fld_nxt + 3'd1;
        if (byte_in[7]) begin
          if (fld_nxt >= 3'd4) begin
            do_fail = 1'b1; fail_code = E_EVENT;
          end
        end else if (acc_nxt > ~tick_nxt) begin
          do_fail = 1'b1; fail_code = E_EVENT;
        end else begin
          tick_nxt = tick_nxt + acc_nxt;
          phase_nxt = P_STATUS;
        end
      end
      P_STATUS: begin
        if (tbl_nxt != '0) tbl_nxt = tbl_nxt - 32'd1; else ovr_nxt = 1'b1;
        if (!byte_in[7]) begin
          if (rs_nxt < 8'h80 || rs_nxt >= ST_SYSEX) begin
            do_fail = 1'b1; fail_code = E_EVENT;
          end else begin
            es_nxt = rs_nxt;
            held_nxt = byte_in;
            if (one_data(es_nxt)) begin
              do_chan = 1'b1; cd1 = byte_in; cd2 = '0;
            end else begin
              phase_nxt = P_CH_D2;
            end
          end
        end else begin
          rs_nxt = (byte_in < ST_SYSEX) ? byte_in : 8'h00;
          es_nxt = byte_in;
          if (byte_in <= 8'hEF) begin
            phase_nxt = P_CH_D1;
          end else if (byte_in == ST_META) begin
            phase_nxt = P_META_TYPE;
          end else if (byte_in == ST_SYSEX || byte_in == ST_ESCAPE) begin
            phase_nxt = P_VAR_LEN; fld_nxt = '0; acc_nxt = '0;
          end else begin
            do_fail = 1'b1; fail_code = E_EVENT;
          end
        end
      end
      P_CH_D1: begin
        if (tbl_nxt != '0) tbl_nxt = tbl_nxt - 32'd1; else ovr_nxt = 1'b1;
        held_nxt = byte_in;
        if (one_data(es_nxt)) begin
          do_chan = 1'b1; cd1 = byte_in; cd2 = '0;
        end else begin
          phase_nxt = P_CH_D2;
        end
      end
      P_CH_D2: begin
        if (tbl_nxt != '0) tbl_nxt = tbl_nxt - 32'd1; else ovr_nxt = 1'b1;
        do_chan = 1'b1; cd1 = held_nxt; cd2 = byte_in;
      end
      P_META_TYPE: begin
        if (tbl_nxt != '0) tbl_nxt = tbl_nxt - 32'd1; else ovr_nxt = 1'b1;
        meta_nxt = byte_in;
        phase_nxt = P_VAR_LEN; fld_nxt = '0; acc_nxt = '0;
      end
      P_VAR_LEN: begin
        if (tbl_nxt != '0) tbl_nxt = tbl_nxt - 32'd1; else ovr_nxt = 1'b1;
        acc_nxt = {acc_nxt[24:0], byte_in[6:0]};
        fld_nxt = fld_nxt + 3'd1;
        if (byte_in[7]) begin
          if (fld_nxt >= 3'd4) begin
            do_fail = 1'b1; fail_code = E_TRUNC;
          end
        end else if (ovr_nxt || acc_nxt > tbl_nxt) begin
          do_fail = 1'b1; fail_code = E_TRUNC;
        end else begin
          skip_nxt = acc_nxt;
          if (es_nxt == ST_META &&
              ((meta_nxt == META_TEMPO && skip_nxt == 32'd3) ||
               (meta_nxt == META_TSIG && skip_nxt >= 32'd2))) begin
            phase_nxt = P_META_DATA; fld_nxt = '0; acc_nxt = '0;
          end else if (skip_nxt == '0) begin
            do_data = 1'b1;
          end else begin
            phase_nxt = P_DATA_SKIP;
          end
        end
      end
      P_META_DATA: begin
        if (tbl_nxt != '0) tbl_nxt = tbl_nxt - 32'd1; else ovr_nxt = 1'b1;
        skip_nxt = skip_nxt - 32'd1;
        fld_nxt = fld_nxt + 3'd1;
        if (meta_nxt == META_TEMPO) begin
          acc_nxt = {acc_nxt[23:0], byte_in};
          if (fld_nxt >= 3'd3) begin
            do_emit = 1'b1; em_kind = K_TEMPO; em_val = acc_nxt[23:0];
          end
        end else if (fld_nxt == 3'd1) begin
          held_nxt = byte_in;
        end else begin
          do_emit = 1'b1; em_kind = K_TIMESIG; em_d1 = held_nxt; em_d2 = byte_in;
        end
        if (do_emit) begin
          if (skip_nxt == '0) do_data = 1'b1;
          else phase_nxt = P_DATA_SKIP;
        end
      end
      P_DATA_SKIP: begin
        if (tbl_nxt != '0) tbl_nxt = tbl_nxt - 32'd1; else ovr_nxt = 1'b1;
        if (skip_nxt != '0) skip_nxt = skip_nxt - 32'd1;
        if (skip_nxt == '0) do_data = 1'b1;
      end
      P_TRK_SKIP: begin
        if (tbl_nxt != '0) tbl_nxt = tbl_nxt - 32'd1;
        if (tbl_nxt == '0) do_fin_trk = 1'b1;
      end
      default: begin
      end
    endcase

    // Classify a completed channel message
    if (do_chan) begin
      if (es_nxt[7:4] == 4'h9 && cd2 != '0) begin
        do_emit = 1'b1; em_kind = K_NOTE_ON; em_ch = es_nxt[3:0];
        em_d1 = cd1; em_d2 = cd2;
        if (!seen_nxt || tick_nxt < early_nxt) begin
          early_nxt = tick_nxt; seen_nxt = 1'b1;
        end
      end else if (es_nxt[7:4] == 4'h8 || es_nxt[7:4] == 4'h9) begin
        do_emit = 1'b1; em_kind = K_NOTE_OFF; em_ch = es_nxt[3:0];
        em_d1 = cd1; em_d2 = cd2;
      end else if (es_nxt[7:4] == 4'hC) begin
        do_emit = 1'b1; em_kind = K_PROGRAM; em_ch = es_nxt[3:0]; em_d1 = cd1;
      end
      do_fin_ev = 1'b1;
    end

    // Emit the decoded event
    if (do_emit) begin
      r0.kind = em_kind; r0.tick = tick_nxt; r0.seq = evc_nxt; r0.track = ctrk_nxt;
      r0.channel = em_ch; r0.data1 = em_d1; r0.data2 = em_d2; r0.value = em_val;
      r0.err = E_NONE; r0.end_tick = '0; r0.start_tick = '0;
      v0 = 1'b1;
      evc_nxt = evc_nxt + 32'd1;
    end

    // Close data of a meta or sysex event
    if (do_data) begin
      if (es_nxt == ST_META && meta_nxt == META_EOT) ended_nxt = 1'b1;
      do_fin_ev = 1'b1;
    end

    // Close the event
    if (do_fin_ev) begin
      if (ovr_nxt) begin
        do_fail = 1'b1; fail_code = E_TRUNC;
      end else if (tbl_nxt == '0) begin
        do_fin_trk = 1'b1;
      end else if (ended_nxt) begin
        phase_nxt = P_TRK_SKIP;
      end else begin
        phase_nxt = P_DELTA; fld_nxt = '0; acc_nxt = '0;
      end
    end

    // Close the track
    if (do_fin_trk) begin
      if (tick_nxt > late_nxt) late_nxt = tick_nxt;
      ctrk_nxt = ctrk_nxt + 16'd1;
      if (ctrk_nxt == ntrk_nxt) begin
        phase_nxt = P_TAIL;
      end else begin
        phase_nxt = P_TRK_TAG; fld_nxt = '0;
      end
    end

    // End of file: done or the error it implies
    if (!do_fail && last_in && !err_nxt && phase_nxt != P_STOP) begin
      if (phase_nxt == P_HDR) begin
        do_fail = 1'b1; fail_code = E_HEADER;
      end else if (phase_nxt == P_TRK_TAG) begin
        do_fail = 1'b1; fail_code = E_TRACK;
      end else if (phase_nxt == P_TAIL) begin
        rn.kind = K_DONE; rn.seq = evc_nxt; rn.track = ctrk_nxt; rn.err = E_NONE;
        rn.end_tick = late_nxt; rn.start_tick = seen_nxt ? early_nxt : 32'd0;
        phase_nxt = P_STOP;
        if (v0) begin
          r1 = rn; v1 = 1'b1;
        end else begin
          r0 = rn; v0 = 1'b1;
        end
      end else begin
        do_fail = 1'b1; fail_code = E_TRUNC;
      end
    end

    // Latch the first error
    if (do_fail && !err_nxt) begin
      err_nxt = 1'b1;
      phase_nxt = P_STOP;
      rn = '0;
      rn.kind = K_ERROR; rn.seq = evc_nxt; rn.track = ctrk_nxt; rn.err = fail_code;
      if (v0) begin
        r1 = rn; v1 = 1'b1;
      end else begin
        r0 = rn; v0 = 1'b1;
      end
    end
  end

  assign push.push0 = step && v0;
  assign push.push1 = step && v1;
  assign res0 = r0;
  assign res1 = r1;

  // Hold or advance parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_HDR; fld_r <= '0; fbc_r <= '0; hlen_r <= '0;
      ntrk_r <= '0; ctrk_r <= '0; tbl_r <= '0; tick_r <= '0;
      rs_r <= '0; es_r <= '0; held_r <= '0; meta_r <= '0;
      acc_r <= '0; skip_r <= '0; evc_r <= '0; early_r <= '0;
      seen_r <= 1'b0; late_r <= '0; ended_r <= 1'b0; err_r <= 1'b0;
      tagbad_r <= 1'b0; ovr_r <= 1'b0; fmt_r <= '0; div_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; fld_r <= fld_nxt; fbc_r <= fbc_nxt; hlen_r <= hlen_nxt;
      ntrk_r <= ntrk_nxt; ctrk_r <= ctrk_nxt; tbl_r <= tbl_nxt; tick_r <= tick_nxt;
      rs_r <= rs_nxt; es_r <= es_nxt; held_r <= held_nxt; meta_r <= meta_nxt;
      acc_r <= acc_nxt; skip_r <= skip_nxt; evc_r <= evc_nxt; early_r <= early_nxt;
      seen_r <= seen_nxt; late_r <= late_nxt; ended_r <= ended_nxt; err_r <= err_nxt;
      tagbad_r <= tagbad_nxt; ovr_r <= ovr_nxt; fmt_r <= fmt_nxt; div_r <= div_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_midi_file_event_parser_unit.sv =====
// Self-checking testbench for the MIDI file event parser: byte streams in, checked events out.
`timescale 1ns / 1ps
module tb_midi_file_event_parser_unit;
  import mfep_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [31:0] out_tick;
  logic [31:0] out_sequence_res;
  logic [15:0] out_track_index;
  logic [3:0]  out_channel;
  logic [7:0]  out_data1;
  logic [7:0]  out_data2;
  logic [23:0] out_value;
  logic [2:0]  out_error_code;
  logic [31:0] out_end_tick;
  logic [31:0] out_music_start_tick;

  midi_file_event_parser_unit DUT (.*);

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser state mirror
  logic [3:0]  ps_phase;
  logic [2:0]  ps_fcnt;
  logic [3:0]  ps_bytes;
  logic [31:0] ps_hlen;
  logic [15:0] ps_ntrk;
  logic [15:0] ps_trk;
  logic [31:0] ps_left;
  logic [31:0] ps_tick;
  logic [7:0]  ps_run;
  logic [7:0]  ps_stat;
  logic [7:0]  ps_held;
  logic [7:0]  ps_meta;
  logic [31:0] ps_acc;
  logic [31:0] ps_skip;
  logic [31:0] ps_evcnt;
  logic [31:0] ps_first_note;
  logic        ps_note_seen;
  logic [31:0] ps_latest_end;
  logic        ps_trk_ended;
  logic        ps_err;
  logic        ps_tag_bad;
  logic        ps_overrun;
  logic [15:0] ps_fmt;
  logic [15:0] ps_div;

  res_t event_queue[$];
  bit   failed;
  int   idle_cycles;
  bit   hold_sender;

  function automatic logic [7:0] mthd_byte(input int i);
    case (i)
      0: return 8'h4D;
      1: return 8'h54;
      2: return 8'h68;
      default: return 8'h64;
    endcase
  endfunction

  function automatic logic [7:0] mtrk_byte(input int i);
    case (i)
      0: return 8'h4D;
      1: return 8'h54;
      2: return 8'h72;
      default: return 8'h6B;
    endcase
  endfunction

  task automatic parser_clear();
    ps_phase = P_HDR; ps_fcnt = 0; ps_bytes = 0; ps_hlen = 0; ps_ntrk = 0; ps_trk = 0;
    ps_left = 0; ps_tick = 0; ps_run = 0; ps_stat = 0; ps_held = 0; ps_meta = 0;
    ps_acc = 0; ps_skip = 0; ps_evcnt = 0; ps_first_note = 0; ps_note_seen = 0;
    ps_latest_end = 0; ps_trk_ended = 0; ps_err = 0; ps_tag_bad = 0; ps_overrun = 0;
    ps_fmt = 0; ps_div = 0;
  endtask

  task automatic queue_result(input logic [2:0] k, input logic [31:0] tk,
                              input logic [3:0] ch, input logic [7:0] d1,
                              input logic [7:0] d2, input logic [23:0] v,
                              input logic [2:0] e, input logic [31:0] et,
                              input logic [31:0] st);
    res_t r;
    r.kind = k; r.tick = tk; r.seq = ps_evcnt; r.track = ps_trk; r.channel = ch;
    r.data1 = d1; r.data2 = d2; r.value = v; r.err = e; r.end_tick = et;
    r.start_tick = st;
    event_queue = {event_queue, r};
  endtask

  task automatic queue_event(input logic [2:0] k, input logic [3:0] ch,
                             input logic [7:0] d1, input logic [7:0] d2,
                             input logic [23:0] v);
    queue_result(k, ps_tick, ch, d1, d2, v, E_NONE, 0, 0);
    ps_evcnt++;
  endtask

  task automatic latch_error(input logic [2:0] code);
    if (!ps_err) begin
      ps_err = 1'b1;
      queue_result(K_ERROR, 0, 0, 0, 0, 0, code, 0, 0);
      ps_phase = P_STOP;
    end
  endtask

  task automatic count_track_byte();
    if (ps_left != 0) ps_left--;
    else ps_overrun = 1'b1;
  endtask

  task automatic open_event();
    ps_phase = P_DELTA; ps_fcnt = 0; ps_acc = 0;
  endtask

  task automatic close_track();
    if (ps_tick > ps_latest_end) ps_latest_end = ps_tick;
    ps_trk++;
    if (ps_trk == ps_ntrk) ps_phase = P_TAIL;
    else begin
      ps_phase = P_TRK_TAG; ps_fcnt = 0;
    end
  endtask

  task automatic close_event();
    if (ps_overrun) latch_error(E_TRUNC);
    else if (ps_left == 0) close_track();
    else if (ps_trk_ended) ps_phase = P_TRK_SKIP;
    else open_event();
  endtask

  task automatic close_data();
    if (ps_stat == ST_META && ps_meta == META_EOT) ps_trk_ended = 1'b1;
    close_event();
  endtask

  function automatic bit single_data(input logic [7:0] st);
    return st[7:4] == 4'hC || st[7:4] == 4'hD;
  endfunction

  task automatic close_channel(input logic [7:0] d1, input logic [7:0] d2);
    logic [3:0] ty;
    ty = ps_stat[7:4];
    if (ty == 4'h9 && d2 != 0) begin
      queue_event(K_NOTE_ON, ps_stat[3:0], d1, d2, 0);
      if (!ps_note_seen || ps_tick < ps_first_note) begin
        ps_first_note = ps_tick; ps_note_seen = 1'b1;
      end
    end else if (ty == 4'h8 || ty == 4'h9) begin
      queue_event(K_NOTE_OFF, ps_stat[3:0], d1, d2, 0);
    end else if (ty == 4'hC) begin
      queue_event(K_PROGRAM, ps_stat[3:0], d1, 0, 0);
    end
    close_event();
  endtask

  task automatic check_header();
    if (ps_tag_bad) latch_error(E_HEADER);
    else if (ps_hlen < 6) latch_error(E_TRUNC);
    else if (ps_fmt > 1 || ps_ntrk == 0) latch_error(E_FORMAT);
    else if (ps_div[15] || ps_div == 0) latch_error(E_DIVISION);
    else begin
      ps_skip = ps_hlen - 6; ps_fcnt = 0;
      ps_phase = (ps_skip != 0) ? P_HDR_SKIP : P_TRK_TAG;
    end
  endtask

  // Advance the parser by one byte and queue the results it produces
  task automatic predict_byte(input logic [7:0] b, input logic first, input logic last);
    logic [3:0] n;
    if (first) parser_clear();
    case (ps_phase)
      P_HDR: begin
        n = ps_bytes;
        if (n < 4) begin
          if (b != mthd_byte(n)) ps_tag_bad = 1'b1;
        end else if (n < 8) ps_hlen = {ps_hlen[23:0], b};
        else if (n < 10) ps_fmt = {ps_fmt[7:0], b};
        else if (n < 12) ps_ntrk = {ps_ntrk[7:0], b};
        else ps_div = {ps_div[7:0], b};
        ps_bytes = n + 4'd1;
        if (n == 13) check_header();
      end
      P_HDR_SKIP: begin
        ps_skip--;
        if (ps_skip == 0) begin
          ps_phase = P_TRK_TAG; ps_fcnt = 0;
        end
      end
      P_TRK_TAG: begin
        if (b != mtrk_byte(ps_fcnt[1:0])) latch_error(E_TRACK);
        else begin
          ps_fcnt++;
          if (ps_fcnt == 4) begin
            ps_phase = P_TRK_LEN; ps_fcnt = 0; ps_left = 0;
          end
        end
      end
      P_TRK_LEN: begin
        ps_left = {ps_left[23:0], b};
        ps_fcnt++;
        if (ps_fcnt == 4) begin
          ps_tick = 0; ps_run = 0; ps_trk_ended = 0; ps_overrun = 0;
          if (ps_left == 0) close_track();
          else open_event();
        end
      end
      P_DELTA: begin
        count_track_byte();
        ps_acc = {ps_acc[24:0], b[6:0]};
        ps_fcnt++;
        if (b[7]) begin
          if (ps_fcnt >= 4) latch_error(E_EVENT);
        end else if (ps_acc > 32'hFFFF_FFFF - ps_tick) latch_error(E_EVENT);
        else begin
          ps_tick += ps_acc; ps_phase = P_STATUS;
        end
      end
      P_STATUS: begin
        count_track_byte();
        if (!b[7]) begin
          if (ps_run < 8'h80 || ps_run >= 8'hF0) latch_error(E_EVENT);
          else begin
            ps_stat = ps_run; ps_held = b;
            if (single_data(ps_stat)) close_channel(b, 0);
            else ps_phase = P_CH_D2;
          end
        end else begin
          ps_run = (b < 8'hF0) ? b : 8'h00;
          ps_stat = b;
          if (b <= 8'hEF) ps_phase = P_CH_D1;
          else if (b == ST_META) ps_phase = P_META_TYPE;
          else if (b == ST_SYSEX || b == ST_ESCAPE) begin
            ps_phase = P_VAR_LEN; ps_fcnt = 0; ps_acc = 0;
          end else latch_error(E_EVENT);
        end
      end
      P_CH_D1: begin
        count_track_byte();
        ps_held = b;
        if (single_data(ps_stat)) close_channel(b, 0);
        else ps_phase = P_CH_D2;
      end
      P_CH_D2: begin
        count_track_byte();
        close_channel(ps_held, b);
      end
      P_META_TYPE: begin
        count_track_byte();
        ps_meta = b; ps_phase = P_VAR_LEN; ps_fcnt = 0; ps_acc = 0;
      end
      P_VAR_LEN: begin
        count_track_byte();
        ps_acc = {ps_acc[24:0], b[6:0]};
        ps_fcnt++;
        if (b[7]) begin
          if (ps_fcnt >= 4) latch_error(E_TRUNC);
        end else if (ps_overrun || ps_acc > ps_left) latch_error(E_TRUNC);
        else begin
          ps_skip = ps_acc;
          if (ps_stat == ST_META && ((ps_meta == META_TEMPO && ps_skip == 3) ||
                                     (ps_meta == META_TSIG && ps_skip >= 2))) begin
            ps_phase = P_META_DATA; ps_fcnt = 0; ps_acc = 0;
          end else if (ps_skip == 0) close_data();
          else ps_phase = P_DATA_SKIP;
        end
      end
      P_META_DATA: begin
        count_track_byte();
        ps_skip--;
        ps_fcnt++;
        if (ps_meta == META_TEMPO) begin
          ps_acc = {ps_acc[23:0], b};
          if (ps_fcnt >= 3) begin
            queue_event(K_TEMPO, 0, 0, 0, ps_acc[23:0]);
            if (ps_skip == 0) close_data();
            else ps_phase = P_DATA_SKIP;
          end
        end else if (ps_fcnt == 1) ps_held = b;
        else begin
          queue_event(K_TIMESIG, 0, ps_held, b, 0);
          if (ps_skip == 0) close_data();
          else ps_phase = P_DATA_SKIP;
        end
      end
      P_DATA_SKIP: begin
        count_track_byte();
        if (ps_skip != 0) ps_skip--;
        if (ps_skip == 0) close_data();
      end
      P_TRK_SKIP: begin
        if (ps_left != 0) ps_left--;
        if (ps_left == 0) close_track();
      end
      default: ;
    endcase
    // End of file verdict
    if (last && !ps_err && ps_phase != P_STOP) begin
      if (ps_phase == P_HDR) latch_error(E_HEADER);
      else if (ps_phase == P_TRK_TAG) latch_error(E_TRACK);
      else if (ps_phase == P_TAIL) begin
        queue_result(K_DONE, 0, 0, 0, 0, 0, E_NONE, ps_latest_end,
                     ps_note_seen ? ps_first_note : 32'd0);
        ps_phase = P_STOP;
      end else latch_error(E_TRUNC);
    end
  endtask

  // Sender: bursts with random gaps
  int burst_left;
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid = 1'b1; in_data_byte = b; in_first_byte = first; in_last_byte = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, first, last);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_file(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == 0, i == bytes.size() - 1);
  endtask

  task automatic add_header(ref logic [7:0] f[$], input logic [15:0] fmt,
                            input logic [15:0] ntrk, input logic [15:0] div);
    f = {8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
         fmt[15:8], fmt[7:0], ntrk[15:8], ntrk[7:0], div[15:8], div[7:0]};
  endtask

  task automatic add_track(ref logic [7:0] f[$], input logic [7:0] body[$]);
    logic [31:0] len;
    len = body.size();
    f = {f, 8'h4D, 8'h54, 8'h72, 8'h6B, len[31:24], len[23:16], len[15:8], len[7:0], body};
  endtask

  // Random track body, mostly well formed
  task automatic random_body(ref logic [7:0] t[$]);
    int nev;
    int kind;
    logic [7:0] st;
    nev = $urandom_range(1, 8);
    t = {};
    for (int e = 0; e < nev; e++) begin
      case ($urandom_range(0, 3))
        0: t = {t, 8'h00};
        1: t = {t, 8'($urandom_range(0, 127))};
        2: t = {t, 8'(8'h80 | $urandom_range(1, 127)), 8'($urandom_range(0, 127))};
        default: t = {t, 8'($urandom_range(128, 255)), 8'($urandom_range(128, 255)),
                      8'($urandom_range(128, 255)), 8'($urandom_range(0, 127))};
      endcase
      kind = $urandom_range(0, 11);
      st = {4'($urandom_range(8, 14)), 4'($urandom)};
      case (kind)
        0, 1, 2: begin
          t = {t, st};
          t = {t, 8'($urandom_range(0, 127))};
          if (!single_data(st)) t = {t, 8'($urandom_range(0, 3) == 0 ? 0 : $urandom)};
        end
        3: begin
          t = {t, 8'($urandom_range(0, 127))};
          t = {t, 8'($urandom_range(0, 127))};
        end
        4: t = {t, ST_META, META_TEMPO, 8'h03, 8'($urandom), 8'($urandom), 8'($urandom)};
        5: t = {t, ST_META, META_TSIG, 8'h04, 8'($urandom), 8'($urandom), 8'h18, 8'h08};
        6: t = {t, ST_META, 8'h03, 8'h02, 8'h41, 8'h42};
        7: t = {t, ST_SYSEX, 8'h02, 8'h7E, ST_ESCAPE};
        8: t = {t, ST_META, META_EOT, 8'h00};
        9: t = {t, 8'($urandom)};
        10: t = {t, ST_META, META_TSIG, 8'h02, 8'($urandom), 8'($urandom)};
        default: t = {t, 8'(8'hC0 | $urandom_range(0, 15)), 8'($urandom_range(0, 127))};
      endcase
    end
    if ($urandom_range(0, 2) != 0) t = {t, 8'h00, ST_META, META_EOT, 8'h00};
  endtask

  task automatic test_header_faults();
    logic [7:0] f[$];
    add_header(f, 0, 1, 96);
    f[2] = 8'h00;
    send_file(f);
    add_header(f, 2, 1, 96);
    send_file(f);
    add_header(f, 1, 0, 96);
    send_file(f);
    add_header(f, 0, 1, 16'h8000);
    send_file(f);
    add_header(f, 0, 1, 0);
    send_file(f);
    add_header(f, 0, 1, 96);
    f[7] = 8'h05;
    send_file(f);
    f = {8'h4D, 8'h54, 8'h68};
    send_file(f);
  endtask

  task automatic test_basic_events();
    logic [7:0] f[$];
    add_header(f, 1, 2, 16'h7FFF);
    f[7] = 8'h08;
    f = {f, 8'hAA, 8'h55};
    add_track(f, {8'h00, ST_META, META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, ST_META, META_TSIG, 8'h04, 8'h06, 8'h03, 8'h18, 8'h08,
                  8'h81, 8'h00, 8'h9F, 8'h7F, 8'h7F, 8'h10, 8'h3C, 8'h00,
                  8'h00, 8'h80, 8'h00, 8'h40, 8'h00, 8'hCF, 8'h7F,
                  8'h00, ST_SYSEX, 8'h01, ST_ESCAPE,
                  8'h00, 8'hE0, 8'h00, 8'h40,
                  8'h00, ST_META, META_EOT, 8'h00, 8'h11, 8'h22});
    add_track(f, {8'h8F, 8'hFF, 8'hFF, 8'h7F, 8'h90, 8'h40, 8'h01});
    f = {f, 8'h12, 8'h34};
    send_file(f);
  endtask

  task automatic test_track_faults();
    logic [7:0] f[$];
    add_header(f, 0, 1, 96);
    f = {f, 8'h4D, 8'h00};
    send_file(f);
    add_header(f, 0, 2, 96);
    add_track(f, {8'h00, ST_META, META_EOT, 8'h00});
    send_file(f);
    add_header(f, 0, 1, 96);
    add_track(f, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    send_file(f);
    add_header(f, 0, 1, 96);
    add_track(f, {8'h00, 8'h40, 8'h00});
    send_file(f);
    add_header(f, 0, 1, 96);
    add_track(f, {8'h00, 8'hF4});
    send_file(f);
    add_header(f, 0, 1, 96);
    add_track(f, {8'h00, ST_META, 8'h01, 8'h05, 8'h00});
    send_file(f);
    add_header(f, 0, 1, 96);
    add_track(f, {8'h00, 8'h90});
    f = {f, 8'h40, 8'h40};
    send_file(f);
    add_header(f, 0, 1, 96);
    add_track(f, {8'h00, 8'h90, 8'h40, 8'h40, 8'h00});
    send_file(f);
  endtask

  task automatic test_random_files(input int budget);
    logic [7:0] f[$];
    logic [7:0] body[$];
    int ntrk;
    int sent;
    sent = 0;
    while (sent < budget) begin
      ntrk = $urandom_range(1, 3);
      add_header(f, $urandom_range(0, 1), ntrk, $urandom_range(1, 16'h7FFF));
      for (int k = 0; k < ntrk; k++) begin
        random_body(body);
        add_track(f, body);
      end
      if ($urandom_range(0, 5) == 0) f = f[0:$urandom_range(0, f.size() - 1)];
      if ($urandom_range(0, 9) == 0) f[$urandom_range(0, f.size() - 1)] = $urandom;
      if ($urandom_range(0, 7) == 0) f = {f, 8'($urandom), 8'($urandom)};
      send_file(f);
      sent += f.size();
      // Let the result queue drain completely once in a while
      if ($urandom_range(0, 15) == 0) wait (event_queue.size() == 0);
    end
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (($time / 400) % 3 == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Check each transfer against the oldest expected result
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (event_queue.size() == 0) begin
        $display("%0t: unexpected result kind=%0d seq=%0d", $time, out_kind, out_sequence_res);
        failed = 1'b1;
      end else begin
        want = event_queue.pop_front();
        if (want != {out_kind, out_tick, out_sequence_res, out_track_index, out_channel,
                     out_data1, out_data2, out_value, out_error_code, out_end_tick,
                     out_music_start_tick}) begin
          $write("%0t: mismatch expected kind=%0d tick=%0d seq=%0d trk=%0d ch=%0d ",
                 $time, want.kind, want.tick, want.seq, want.track, want.channel);
          $display("d1=%0h d2=%0h val=%0h err=%0d end=%0d start=%0d",
                   want.data1, want.data2, want.value, want.err, want.end_tick,
                   want.start_tick);
          $write("%0t: mismatch actual   kind=%0d tick=%0d seq=%0d trk=%0d ch=%0d ",
                 $time, out_kind, out_tick, out_sequence_res, out_track_index, out_channel);
          $display("d1=%0h d2=%0h val=%0h err=%0d end=%0d start=%0d",
                   out_data1, out_data2, out_value, out_error_code, out_end_tick,
                   out_music_start_tick);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    failed = 1'b0; idle_cycles = 0; burst_left = 0;
    in_valid = 1'b0; in_data_byte = 8'h00; in_first_byte = 1'b0; in_last_byte = 1'b0;
    parser_clear();
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_header_faults();
    test_basic_events();
    test_track_faults();
    wait (event_queue.size() == 0);
    test_random_files(1450);
    wait (event_queue.size() == 0);
    repeat (20) @(negedge clk);
    if (!failed) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
